// ===== src/gqre_pkg.sv =====
// Package for the gray quantizer with frame RMS error.
// Holds the queue item type, the back-end state type, constants and the step tables.
// No dependencies; every other file imports it.
package gqre_pkg;

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int LEVELS_W    = 9;
    localparam int SQ_W        = 14;
    localparam int RECIP_W     = 18;
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEVELS_W-1:0] LEVELS_RESET = 9'd2;
    localparam logic                REG_LEVELS   = 1'b0;

    localparam logic [14:0] LUMA_RED   = 15'd36;
    localparam logic [14:0] LUMA_GREEN = 15'd53;
    localparam logic [14:0] LUMA_BLUE  = 15'd11;
    localparam logic [14:0] LUMA_RECIP = 15'd20972;
    localparam int          LUMA_SHIFT = 21;
    localparam int          STEP_SHIFT = 17;

    typedef logic [7:0]         step_table_t  [256];
    typedef logic [RECIP_W-1:0] recip_table_t [256];

    typedef struct packed {
        logic [7:0]      gray;
        logic [SQ_W-1:0] sq;
        logic            last;
    } gqre_item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQRT,
        BK_RESULT
    } back_state_t;

    function automatic step_table_t build_step_table();
        step_table_t t;
        int dd;
        int s;
        for (int d = 0; d < 256; d++)
        begin
            dd = (d == 0) ? 1 : d;
            s  = 1;
            for (int k = 1; k < 256; k++)
            begin
                if (k * dd <= 255)
                begin
                    s = k;
                end
            end
            t[d] = 8'(s);
        end
        return t;
    endfunction

    localparam step_table_t STEP_TABLE = build_step_table();

    // ceil(2^STEP_SHIFT / step), found by a bitwise search
    function automatic recip_table_t build_recip_table();
        recip_table_t t;
        int s;
        int m;
        for (int d = 0; d < 256; d++)
        begin
            s = int'(STEP_TABLE[d]);
            m = 0;
            for (int b = RECIP_W - 1; b >= 0; b--)
            begin
                if (((m | (1 << b)) * s) < (1 << STEP_SHIFT))
                begin
                    m = m | (1 << b);
                end
            end
            t[d] = RECIP_W'(m + 1);
        end
        return t;
    endfunction

    localparam recip_table_t RECIP_TABLE = build_recip_table();

endpackage

// ===== src/gqre_front.sv =====
// Front end: accepts pixels, forms luma, quantizes it and squares the error.
// Four-stage pipeline with credit against the queue fill; uses gqre_pkg.
module gqre_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gqre_pkg::LEVELS_W-1:0] levels,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic                          last_pixel,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [gqre_pkg::QUEUE_CW-1:0] queue_count,
    output logic                          push,
    output gqre_pkg::gqre_item_t          push_item
);
    import gqre_pkg::*;

    logic [3:0]  valid_reg;
    logic [3:0]  valid_next;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic [3:0]  last_reg;
    logic [3:0]  last_next;
    logic [7:0]  y2_reg;
    logic [7:0]  y2_next;
    logic [7:0]  y3_reg;
    logic [7:0]  qi_reg;
    logic [7:0]  qi_next;
    logic [7:0]  gray_reg;
    logic [7:0]  gray_next;
    logic [7:0]  diff_reg;
    logic [7:0]  diff_next;

    logic        accept;
    logic [4:0]  credit_used;
    logic [7:0]  div_sel;
    logic [7:0]  step;
    logic [14:0] luma_sum;
    logic [29:0] luma_prod;
    logic [25:0] qi_prod;
    logic [15:0] base_prod;
    logic [7:0]  base;
    logic [7:0]  rem;
    logic        round_up;
    logic [8:0]  q_full;
    logic [15:0] sq_prod;

    assign credit_used = 5'(queue_count) + 5'(valid_reg[0]) + 5'(valid_reg[1])
                       + 5'(valid_reg[2]) + 5'(valid_reg[3]);
    assign in_stall    = credit_used >= 5'(QUEUE_DEPTH);
    assign accept      = in_valid && !in_stall;

    always_comb
    begin
        if (levels inside {[9'd0:9'd1]})
        begin
            div_sel = 8'd1;
        end
        else if (levels > 9'd256)
        begin
            div_sel = 8'd255;
        end
        else
        begin
            div_sel = levels[7:0] - 8'd1;
        end
    end

    assign step = STEP_TABLE[div_sel];

    assign luma_sum  = LUMA_RED * 15'(red_reg) + LUMA_GREEN * 15'(green_reg)
                     + LUMA_BLUE * 15'(blue_reg);
    assign luma_prod = 30'(luma_sum) * 30'(LUMA_RECIP);
    assign y2_next   = luma_prod[LUMA_SHIFT +: 8];

    assign qi_prod   = 26'(y2_reg) * 26'(RECIP_TABLE[div_sel]);
    assign qi_next   = qi_prod[STEP_SHIFT +: 8];

    assign base_prod = 16'(qi_reg) * 16'(step);
    assign base      = base_prod[7:0];
    assign rem       = y3_reg - base;
    assign round_up  = rem > (step >> 1);
    assign q_full    = round_up ? (9'(base) + 9'(step)) : 9'(base);
    assign gray_next = q_full[8] ? 8'd255 : q_full[7:0];
    assign diff_next = round_up ? (step - rem) : rem;

    assign sq_prod   = 16'(diff_reg) * 16'(diff_reg);

    assign valid_next = {valid_reg[2:0], accept};
    assign last_next  = {last_reg[2:0], last_pixel};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
        end
        last_reg <= last_next;
        y2_reg   <= y2_next;
        y3_reg   <= y2_reg;
        qi_reg   <= qi_next;
        gray_reg <= gray_next;
        diff_reg <= diff_next;
    end

    assign push           = valid_reg[3];
    assign push_item.gray = gray_reg;
    assign push_item.sq   = sq_prod[SQ_W-1:0];
    assign push_item.last = last_reg[3];

endmodule

// ===== src/gqre_queue.sv =====
// Short queue between the front end and the back end.
// Holds quantized items until the accumulator takes them; uses gqre_pkg.
module gqre_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  gqre_pkg::gqre_item_t          push_item,
    input  logic                          pop,
    output gqre_pkg::gqre_item_t          head_item,
    output logic                          head_valid,
    output logic [gqre_pkg::QUEUE_CW-1:0] count
);
    import gqre_pkg::*;

    gqre_item_t          mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item  = mem_reg[rd_ptr_reg];
    assign head_valid = count_reg != '0;
    assign count      = count_reg;

endmodule

// ===== src/gqre_back.sv =====
// Back end: accumulates squared error, then divides and takes the root at frame end.
// Bit-serial divider and digit-by-digit square root feed the output register; uses gqre_pkg.
module gqre_back #(
    parameter int FRAME_PIXEL_BITS = 22
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gqre_pkg::gqre_item_t head_item,
    input  logic                 head_valid,
    output logic                 pop,
    output logic [7:0]           gray,
    output logic [15:0]          rms_error,
    output logic                 rms_valid,
    output logic                 out_valid,
    input  logic                 out_stall
);
    import gqre_pkg::*;

    localparam int CW  = FRAME_PIXEL_BITS + 1;
    localparam int SW  = FRAME_PIXEL_BITS + 14;
    localparam int QW  = SW + 16;
    localparam int DCW = $clog2(QW);

    back_state_t    state_reg;
    back_state_t    state_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic [SW-1:0]  sum_reg;
    logic [SW-1:0]  sum_next;
    logic [CW-1:0]  rem_reg;
    logic [CW-1:0]  rem_next;
    logic [QW-1:0]  dq_reg;
    logic [QW-1:0]  dq_next;
    logic [CW-1:0]  divisor_reg;
    logic [CW-1:0]  divisor_next;
    logic [DCW-1:0] iter_reg;
    logic [DCW-1:0] iter_next;
    logic [31:0]    x_reg;
    logic [31:0]    x_next;
    logic [31:0]    root_reg;
    logic [31:0]    root_next;
    logic [31:0]    bit_reg;
    logic [31:0]    bit_next;
    logic [7:0]     hold_gray_reg;
    logic [7:0]     hold_gray_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [7:0]     gray_reg;
    logic [7:0]     gray_next;
    logic [15:0]    rms_reg;
    logic [15:0]    rms_next;
    logic           rms_valid_reg;
    logic           rms_valid_next;

    logic           slot_free;
    logic [CW-1:0]  cnt_inc;
    logic [SW:0]    sum_add;
    logic [SW-1:0]  sum_sat;
    logic [CW:0]    rem_sh;
    logic           div_fits;
    logic [CW:0]    rem_sub;
    logic [QW-1:0]  quotient;
    logic [32:0]    trial;
    logic           root_fits;

    assign slot_free = !out_valid_reg || !out_stall;
    assign cnt_inc   = (&cnt_reg) ? cnt_reg : cnt_reg + CW'(1);
    assign sum_add   = {1'b0, sum_reg} + (SW + 1)'(head_item.sq);
    assign sum_sat   = sum_add[SW] ? '1 : sum_add[SW-1:0];
    assign rem_sh    = {rem_reg, dq_reg[QW-1]};
    assign div_fits  = rem_sh >= {1'b0, divisor_reg};
    assign rem_sub   = rem_sh - {1'b0, divisor_reg};
    assign quotient  = {dq_reg[QW-2:0], div_fits};
    assign trial     = {1'b0, root_reg} + {1'b0, bit_reg};
    assign root_fits = {1'b0, x_reg} >= trial;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        divisor_next   = divisor_reg;
        iter_next      = iter_reg;
        x_next         = x_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        hold_gray_next = hold_gray_reg;
        out_valid_next = out_valid_reg && out_stall;
        gray_next      = gray_reg;
        rms_next       = rms_reg;
        rms_valid_next = rms_valid_reg;
        pop            = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && slot_free)
                begin
                    pop = 1'b1;
                    if (head_item.last)
                    begin
                        cnt_next       = '0;
                        sum_next       = '0;
                        dq_next        = {sum_sat, 16'h0000};
                        rem_next       = '0;
                        divisor_next   = cnt_inc;
                        iter_next      = DCW'(QW - 1);
                        hold_gray_next = head_item.gray;
                        state_next     = BK_DIV;
                    end
                    else
                    begin
                        cnt_next       = cnt_inc;
                        sum_next       = sum_sat;
                        out_valid_next = 1'b1;
                        gray_next      = head_item.gray;
                        rms_next       = '0;
                        rms_valid_next = 1'b0;
                    end
                end
            end
            BK_DIV:
            begin
                rem_next  = div_fits ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
                dq_next   = quotient;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    if (|quotient[QW-1:32])
                    begin
                        root_next  = 32'h0000_FFFF;
                        state_next = BK_RESULT;
                    end
                    else
                    begin
                        x_next     = quotient[31:0];
                        root_next  = '0;
                        bit_next   = 32'h4000_0000;
                        state_next = BK_SQRT;
                    end
                end
            end
            BK_SQRT:
            begin
                if (root_fits)
                begin
                    x_next    = x_reg - trial[31:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = BK_RESULT;
                end
            end
            BK_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    gray_next      = hold_gray_reg;
                    rms_next       = root_reg[15:0];
                    rms_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        dq_reg        <= dq_next;
        divisor_reg   <= divisor_next;
        iter_reg      <= iter_next;
        x_reg         <= x_next;
        root_reg      <= root_next;
        bit_reg       <= bit_next;
        hold_gray_reg <= hold_gray_next;
        gray_reg      <= gray_next;
        rms_reg       <= rms_next;
        rms_valid_reg <= rms_valid_next;
    end

    assign gray      = gray_reg;
    assign rms_error = rms_reg;
    assign rms_valid = rms_valid_reg;
    assign out_valid = out_valid_reg;

endmodule

// ===== src/gray_quantizer_rms_error_core.sv =====
// Gray quantizer with frame RMS error: top level, levels register and block wiring.
// Ordinary pixel: front-end stages, queue and back-end output register, one pixel per cycle
// sustained while out_stall is low. Last pixel of a frame: the back end runs the divider,
// then root (skipped on quotient overflow) and result state, while queue and front end fill.
// Reset (rst_n low, asynchronous) empties pipeline and queue, clears count and sum,
// and sets levels to 2. Depends on gqre_pkg, gqre_front, gqre_queue, gqre_back.
module gray_quantizer_rms_error_core #(
    parameter int FRAME_PIXEL_BITS = 22
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gqre_pkg::PADDR_W-1:0] paddr,
    input  logic [gqre_pkg::PDATA_W-1:0] pwdata,
    output logic [gqre_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic [7:0]                   red,
    input  logic [7:0]                   green,
    input  logic [7:0]                   blue,
    input  logic                         last_pixel,
    input  logic                         in_valid,
    output logic                         in_stall,
    output logic [7:0]                   gray,
    output logic [15:0]                  rms_error,
    output logic                         rms_valid,
    output logic                         out_valid,
    input  logic                         out_stall
);
    import gqre_pkg::*;

    logic [LEVELS_W-1:0] levels_reg;
    logic [LEVELS_W-1:0] levels_next;
    logic                cfg_write;
    logic                push;
    gqre_item_t          push_item;
    logic                pop;
    gqre_item_t          head_item;
    logic                head_valid;
    logic [QUEUE_CW-1:0] queue_count;

    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite && pready && (paddr[2] == REG_LEVELS);
    assign levels_next = cfg_write ? pwdata[LEVELS_W-1:0] : levels_reg;
    assign prdata      = (paddr[2] == REG_LEVELS) ? PDATA_W'(levels_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= LEVELS_RESET;
        end
        else
        begin
            levels_reg <= levels_next;
        end
    end

    gqre_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .levels      (levels_reg),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_pixel  (last_pixel),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .queue_count (queue_count),
        .push        (push),
        .push_item   (push_item)
    );

    gqre_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_item  (head_item),
        .head_valid (head_valid),
        .count      (queue_count)
    );

    gqre_back #(
        .FRAME_PIXEL_BITS (FRAME_PIXEL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_item  (head_item),
        .head_valid (head_valid),
        .pop        (pop),
        .gray       (gray),
        .rms_error  (rms_error),
        .rms_valid  (rms_valid),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

endmodule

// ===== src/gqre_checker.sv =====
// Port-level checker for the gray quantizer core, with its bind to the top level.
// Watches handshakes, result beats and the levels register; uses gqre_pkg.
module gqre_port_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [gqre_pkg::PADDR_W-1:0] paddr,
    input logic [gqre_pkg::PDATA_W-1:0] pwdata,
    input logic [gqre_pkg::PDATA_W-1:0] prdata,
    input logic                         pready,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [7:0]                   gray,
    input logic [15:0]                  rms_error,
    input logic                         rms_valid,
    input logic                         out_valid,
    input logic                         out_stall
);
    import gqre_pkg::*;

    logic [4:0] pending_reg;
    logic [4:0] pending_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input beat dropped while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(gray) && $stable(rms_error)
            && $stable(rms_valid))
        else $error("result beat changed while stalled");

    a_rms_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rms_valid |-> rms_error == 16'h0000)
        else $error("rms_error set on a beat without frame result");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 5'd0)
        else $error("result beat without an accepted pixel");

    a_levels_rd: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr[2] == REG_LEVELS
            |=> paddr[2] != REG_LEVELS
                || prdata == PDATA_W'($past(pwdata[LEVELS_W-1:0])))
        else $error("levels readback differs from last write");

endmodule

bind gray_quantizer_rms_error_core gqre_port_checker u_gqre_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .gray      (gray),
    .rms_error (rms_error),
    .rms_valid (rms_valid),
    .out_valid (out_valid),
    .out_stall (out_stall)
);
